### sv/epd_pkg.sv
`timescale 1ns / 1ps

package epd_pkg;

  localparam int NUM_CH      = 3;
  localparam int ANGLE_W     = 13;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 3;
  localparam int PAYLOAD_LEN = 2 * NUM_CH;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;

  localparam logic [POS_W-1:0] POS_HUNT = 3'd0;
  localparam logic [POS_W-1:0] POS_CSUM = 3'd7;

  // bit 13 of a channel word, in its high byte
  localparam int ERR_BIT_HI = ANGLE_W - BYTE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH2 = 2'd2;

  typedef logic [ANGLE_W-1:0] angle_t;

  // one deframed packet: error flag and raw position per channel
  typedef struct packed {
    logic [NUM_CH-1:0]              err;
    logic [NUM_CH-1:0][ANGLE_W-1:0] raw;
  } pkt_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    angle_t               data;
  } cfg_wr_t;

endpackage

### sv/epd_front.sv
`timescale 1ns / 1ps

module epd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  output logic                 push_valid,
  input  logic                 push_ready,
  output epd_pkg::pkt_t        push_pkt
);
  import epd_pkg::*;

  logic [POS_W-1:0]                   pos;
  logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] payload;
  logic [POS_W-1:0]                   slot;
  logic                               accept;

  assign rx_stall   = (pos == POS_CSUM) && !push_ready;
  assign accept     = rx_valid && !rx_stall;
  assign slot       = POS_W'(pos - 3'd1);
  assign push_valid = accept && (pos == POS_CSUM);

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      push_pkt.err[ch] = payload[2*ch+1][ERR_BIT_HI];
      push_pkt.raw[ch] = {payload[2*ch+1][ERR_BIT_HI-1:0], payload[2*ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
    end else if (accept) begin
      if (pos == POS_HUNT) begin
        if (rx_byte == HDR_BYTE) begin
          pos <= 3'd1;
        end
      end else if (pos == POS_CSUM) begin
        pos <= POS_HUNT;
      end else begin
        pos <= POS_W'(pos + 3'd1);
      end
    end
  end

  // payload bytes, first in the low slot
  always_ff @(posedge clk) begin
    if (accept && pos != POS_HUNT && pos != POS_CSUM) begin
      payload[slot] <= rx_byte;
    end
  end

endmodule

### sv/epd_fifo.sv
`timescale 1ns / 1ps

module epd_fifo #(
  parameter int DEPTH = epd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  epd_pkg::pkt_t push_pkt,
  output logic          head_valid,
  input  logic          pop,
  output epd_pkg::pkt_t head_pkt
);
  import epd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  pkt_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_pkt   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

endmodule

### sv/epd_back.sv
`timescale 1ns / 1ps

module epd_back (
  input  logic                                        clk,
  input  logic                                        rst,
  input  epd_pkg::cfg_wr_t                            cfg_wr,
  input  logic                                        head_valid,
  input  epd_pkg::pkt_t                               head_pkt,
  output logic                                        pop,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [epd_pkg::NUM_CH-1:0][epd_pkg::ANGLE_W-1:0] out_angle,
  output logic [epd_pkg::NUM_CH-1:0]                  out_ok
);
  import epd_pkg::*;

  angle_t [NUM_CH-1:0] offset;
  angle_t [NUM_CH-1:0] angle_next;

  assign pop = head_valid && (!out_valid || !out_stall);

  // error flag forces the angle to zero
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      angle_next[ch] = head_pkt.err[ch] ? '0
                     : ANGLE_W'(head_pkt.raw[ch] - offset[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_OFFSET_CH0: offset[0] <= cfg_wr.data;
        CFG_OFFSET_CH1: offset[1] <= cfg_wr.data;
        CFG_OFFSET_CH2: offset[2] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_angle <= angle_next;
      out_ok    <= ~head_pkt.err;
    end
  end

endmodule

### sv/encoder_packet_deframer.sv
`timescale 1ns / 1ps
// a result passes through the queue and the output register after its checksum beat is accepted
// throughput: one byte beat per cycle while rx_stall is low; one result per packet of eight beats
// a two-entry queue between framer and output register absorbs output stalls
// rst (synchronous) returns to header hunting, drops queued results, clears offsets
// config writes are always ready and take effect on the next cycle

module encoder_packet_deframer #(
  parameter int QUEUE_DEPTH = epd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] angle_ch0,
  output logic [12:0] angle_ch1,
  output logic [12:0] angle_ch2,
  output logic        valid_ch0,
  output logic        valid_ch1,
  output logic        valid_ch2
);
  import epd_pkg::*;

  logic                            push_valid;
  logic                            push_ready;
  pkt_t                            push_pkt;
  logic                            head_valid;
  pkt_t                            head_pkt;
  logic                            pop;
  cfg_wr_t                         cfg_wr;
  logic [NUM_CH-1:0][ANGLE_W-1:0]  out_angle;
  logic [NUM_CH-1:0]               out_ok;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  epd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt)
  );

  epd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt),
    .head_valid (head_valid),
    .pop        (pop),
    .head_pkt   (head_pkt)
  );

  epd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .head_valid (head_valid),
    .head_pkt   (head_pkt),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_angle  (out_angle),
    .out_ok     (out_ok)
  );

  assign angle_ch0 = out_angle[0];
  assign angle_ch1 = out_angle[1];
  assign angle_ch2 = out_angle[2];
  assign valid_ch0 = out_ok[0];
  assign valid_ch1 = out_ok[1];
  assign valid_ch2 = out_ok[2];

endmodule

### sv/epd_checker.sv
`timescale 1ns / 1ps

module epd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] angle_ch0,
  input logic [12:0] angle_ch1,
  input logic [12:0] angle_ch2,
  input logic        valid_ch0,
  input logic        valid_ch1,
  input logic        valid_ch2
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_ch0) && $stable(angle_ch1)
      && $stable(angle_ch2) && $stable(valid_ch0) && $stable(valid_ch1)
      && $stable(valid_ch2))
    else $error("stalled result beat changed");

  // flagged channels report a zero angle
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_ch0 || angle_ch0 == 13'd0) && (valid_ch1 || angle_ch1 == 13'd0)
      && (valid_ch2 || angle_ch2 == 13'd0))
    else $error("invalid channel with nonzero angle");

  // a result rising from idle comes from a byte beat taken before the queue push and output register
  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(rx_valid && !rx_stall, 2))
    else $error("result beat without a checksum beat");

endmodule

bind encoder_packet_deframer epd_checker u_epd_checker (.*);
